/* sv/cubemap_to_equirect_coord_macros.svh */
// assertion macros for the cube strip to equirectangular mapper
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef CUBEMAP_TO_EQUIRECT_COORD_MACROS_SVH
`define CUBEMAP_TO_EQUIRECT_COORD_MACROS_SVH

// same-cycle implication
`define C2E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define C2E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/c2e_pkg.sv */
// shared types and constants of the cube strip to equirectangular mapper
// no dependencies
package c2e_pkg;

    localparam int ANG_W = 34;

    typedef logic [2:0] t_face;
    localparam t_face FACE_LEFT   = 3'd0;
    localparam t_face FACE_FRONT  = 3'd1;
    localparam t_face FACE_RIGHT  = 3'd2;
    localparam t_face FACE_BACK   = 3'd3;
    localparam t_face FACE_TOP    = 3'd4;
    localparam t_face FACE_BOTTOM = 3'd5;

    localparam int CFG_FACE_SIZE   = 0;
    localparam int CFG_PANO_WIDTH  = 1;
    localparam int CFG_PANO_HEIGHT = 2;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sh0_8000_0000;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic [15:0] INV_GAIN = 16'd39797;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [24] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
        34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
        34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
        34'sd652, 34'sd326, 34'sd163, 34'sd81
    };

    // per-stage control travelling with each request
    typedef struct packed {
        logic valid;
        logic byp;
    } t_ctl;

endpackage

/* sv/c2e_cell.sv */
// one cordic vectoring micro-rotation, registered
// depends on c2e_pkg
module c2e_cell import c2e_pkg::*; #(
    parameter int W      = 34,
    parameter int SIDE_W = 8,
    parameter int STAGE  = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_ctl                    i_ctl,
    input  logic signed [W-1:0]     i_x,
    input  logic signed [W-1:0]     i_y,
    input  logic signed [ANG_W-1:0] i_z,
    input  logic [SIDE_W-1:0]       i_side,
    output t_ctl                    o_ctl,
    output logic signed [W-1:0]     o_x,
    output logic signed [W-1:0]     o_y,
    output logic signed [ANG_W-1:0] o_z,
    output logic [SIDE_W-1:0]       o_side
);

    t_ctl                    r_ctl;
    logic signed [W-1:0]     r_x, r_y, n_x, n_y;
    logic signed [ANG_W-1:0] r_z, n_z;
    logic [SIDE_W-1:0]       r_side;
    logic signed [W-1:0]     dx, dy;

    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (i_ctl.byp) begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end else if (i_y >= 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN_TAB[STAGE];
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

/* sv/c2e_vector.sv */
// one cordic vectoring pass: axis handling, chain of cells, gain correction
// depends on c2e_pkg and c2e_cell
module c2e_vector import c2e_pkg::*; #(
    parameter int W      = 34,
    parameter int SIDE_W = 8,
    parameter int STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [W-1:0]     i_x,
    input  logic signed [W-1:0]     i_y,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic signed [W-1:0]     o_mag,
    output logic signed [ANG_W-1:0] o_ang,
    output logic [SIDE_W-1:0]       o_side
);

    t_ctl                    c_ctl  [STAGES+1];
    logic signed [W-1:0]     c_x    [STAGES+1];
    logic signed [W-1:0]     c_y    [STAGES+1];
    logic signed [ANG_W-1:0] c_z    [STAGES+1];
    logic [SIDE_W-1:0]       c_side [STAGES+1];

    t_ctl                    r_p_ctl, n_p_ctl;
    logic signed [W-1:0]     r_p_x, r_p_y, n_p_x, n_p_y;
    logic signed [ANG_W-1:0] r_p_z, n_p_z;
    logic [SIDE_W-1:0]       r_p_side;

    // on an axis the result is exact and the cells just pass it along
    always_comb begin
        n_p_ctl.valid = i_valid;
        n_p_ctl.byp   = 1'b0;
        n_p_x = i_x;
        n_p_y = i_y;
        n_p_z = '0;
        if (i_y == '0) begin
            n_p_ctl.byp = 1'b1;
            n_p_x = (i_x < 0) ? -i_x : i_x;
            n_p_z = (i_x < 0) ? HALF_TURN : '0;
        end else if (i_x == '0) begin
            n_p_ctl.byp = 1'b1;
            n_p_x = (i_y < 0) ? -i_y : i_y;
            n_p_y = '0;
            n_p_z = (i_y > 0) ? QUARTER_TURN : -QUARTER_TURN;
        end else if (i_x < 0) begin
            n_p_x = -i_x;
            n_p_y = -i_y;
            n_p_z = (i_y > 0) ? HALF_TURN : -HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else if (i_en) begin
            r_p_ctl <= n_p_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_x    <= n_p_x;
            r_p_y    <= n_p_y;
            r_p_z    <= n_p_z;
            r_p_side <= i_side;
        end
    end

    assign c_ctl[0]  = r_p_ctl;
    assign c_x[0]    = r_p_x;
    assign c_y[0]    = r_p_y;
    assign c_z[0]    = r_p_z;
    assign c_side[0] = r_p_side;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        c2e_cell #(
            .W      (W),
            .SIDE_W (SIDE_W),
            .STAGE  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_ctl   (c_ctl[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // gain correction: clamp, multiply, then round
    t_ctl                    r_q_ctl;
    logic signed [W-1:0]     r_q_x, n_q_x;
    logic [W+15:0]           r_q_prod, n_q_prod;
    logic signed [ANG_W-1:0] r_q_z;
    logic [SIDE_W-1:0]       r_q_side;

    logic                    r_m_valid;
    logic signed [W-1:0]     r_m_mag, n_m_mag;
    logic signed [ANG_W-1:0] r_m_z;
    logic [SIDE_W-1:0]       r_m_side;
    logic [W+15:0]           m_round;

    always_comb begin
        if (c_ctl[STAGES].byp) begin
            n_q_x = c_x[STAGES];
        end else begin
            n_q_x = (c_x[STAGES] < 0) ? '0 : c_x[STAGES];
        end
        n_q_prod = (W+16)'($unsigned(n_q_x)) * (W+16)'(INV_GAIN);
    end

    always_comb begin
        m_round = r_q_prod + (W+16)'(32768);
        n_m_mag = r_q_ctl.byp ? r_q_x : signed'(m_round[W+15:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_ctl   <= '0;
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_q_ctl   <= c_ctl[STAGES];
            r_m_valid <= r_q_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_x    <= n_q_x;
            r_q_prod <= n_q_prod;
            r_q_z    <= c_z[STAGES];
            r_q_side <= c_side[STAGES];
            r_m_mag  <= n_m_mag;
            r_m_z    <= r_q_z;
            r_m_side <= r_q_side;
        end
    end

    assign o_valid = r_m_valid;
    assign o_mag   = r_m_mag;
    assign o_ang   = r_m_z;
    assign o_side  = r_m_side;

endmodule

/* sv/cubemap_to_equirect_coord.sv */
// top level of the cube strip to equirectangular coordinate mapper
// depends on c2e_pkg, c2e_vector, c2e_cell and the assertion macro header
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  request   | i_valid / o_ready    | i_strip_x, i_strip_y
//  result    | o_valid / i_ready    | o_pano_x, o_pano_y, o_face_index
//  config    | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// one request per clock while o_ready is high; the path to the output
// register runs through the two unrolled cordic cell chains
// synchronous active-low reset clears all valid flags and loads the
// default face and panorama sizes
// a stalled result sits in the output register, one more in a skid
// register; only when the skid is full does the whole pipeline hold
`include "cubemap_to_equirect_coord_macros.svh"

module cubemap_to_equirect_coord import c2e_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [18:0] i_strip_x,
    input  logic [15:0] i_strip_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [18:0] o_pano_x,
    output logic [17:0] o_pano_y,
    output logic [2:0]  o_face_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    // face size in subpixels and the width holding five of it
    localparam int SW = 13 + FRAC_BITS;
    localparam int MW = (SW + 3 > 19) ? SW + 3 : 19;
    // signed direction components and the cordic datapath around them
    localparam int VW = MW + 2;
    localparam int W  = VW + 8 + 4;
    localparam int PRODW = 52;

    // configuration registers
    logic [12:0] r_face_size;
    logic [14:0] r_pano_width;
    logic [13:0] r_pano_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size   <= 13'd512;
            r_pano_width  <= 15'd2048;
            r_pano_height <= 14'd1024;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 2'(CFG_FACE_SIZE)) begin
                r_face_size <= i_cfg_data[12:0];
            end
            if (i_cfg_idx == 2'(CFG_PANO_WIDTH)) begin
                r_pano_width <= i_cfg_data;
            end
            if (i_cfg_idx == 2'(CFG_PANO_HEIGHT)) begin
                r_pano_height <= i_cfg_data[13:0];
            end
        end
    end

    // whole pipeline moves unless the skid register is holding a result
    logic en;
    logic r_skid_v;
    assign en      = !r_skid_v;
    assign o_ready = en;

    // face selection and direction vector
    logic [MW-1:0] s1, s2, s3, s4, s5, xs_e, base, u;
    t_face         n_face;
    logic signed [VW-1:0] sv, u2, y2, n_vx, n_vy, n_vz;

    always_comb begin
        s1   = MW'({r_face_size, {FRAC_BITS{1'b0}}});
        s2   = s1 << 1;
        s3   = s1 + s2;
        s4   = s1 << 2;
        s5   = s4 + s1;
        xs_e = MW'(i_strip_x);
        // anything at or past five faces, also a zero face size, is bottom
        priority if (xs_e < s1) begin
            n_face = FACE_LEFT;   base = '0;
        end else if (xs_e < s2) begin
            n_face = FACE_FRONT;  base = s1;
        end else if (xs_e < s3) begin
            n_face = FACE_RIGHT;  base = s2;
        end else if (xs_e < s4) begin
            n_face = FACE_BACK;   base = s3;
        end else if (xs_e < s5) begin
            n_face = FACE_TOP;    base = s4;
        end else begin
            n_face = FACE_BOTTOM; base = s5;
        end
        u  = xs_e - base;
        sv = signed'({2'b00, s1});
        u2 = signed'({1'b0, u, 1'b0});
        y2 = signed'({{(VW-17){1'b0}}, i_strip_y, 1'b0});
        unique case (n_face)
            FACE_LEFT: begin
                n_vx = sv - u2; n_vy = sv;      n_vz = sv - y2;
            end
            FACE_FRONT: begin
                n_vx = -sv;     n_vy = sv - u2; n_vz = sv - y2;
            end
            FACE_RIGHT: begin
                n_vx = u2 - sv; n_vy = -sv;     n_vz = sv - y2;
            end
            FACE_BACK: begin
                n_vx = sv;      n_vy = u2 - sv; n_vz = sv - y2;
            end
            FACE_TOP: begin
                n_vx = sv - y2; n_vy = sv - u2; n_vz = sv;
            end
            default: begin
                n_vx = y2 - sv; n_vy = sv - u2; n_vz = -sv;
            end
        endcase
    end

    logic                 r_a_valid;
    t_face                r_a_face;
    logic signed [VW-1:0] r_a_vx, r_a_vy, r_a_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_face <= n_face;
            r_a_vx   <= n_vx;
            r_a_vy   <= n_vy;
            r_a_vz   <= n_vz;
        end
    end

    // guard bits: components scaled by 256 ahead of the cordic
    logic signed [W-1:0] g_vx, g_vy, g_vz;
    assign g_vx = W'(r_a_vx) <<< 8;
    assign g_vy = W'(r_a_vy) <<< 8;
    assign g_vz = W'(r_a_vz) <<< 8;

    // first pass: longitude and horizontal radius
    logic                    p1_valid;
    logic signed [W-1:0]     p1_rxy;
    logic signed [ANG_W-1:0] p1_lon;
    logic [W+2:0]            p1_side;

    c2e_vector #(
        .W      (W),
        .SIDE_W (W + 3),
        .STAGES (CORDIC_STAGES)
    ) u_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_valid),
        .i_x     (g_vx),
        .i_y     (g_vy),
        .i_side  ({r_a_face, g_vz}),
        .o_valid (p1_valid),
        .o_mag   (p1_rxy),
        .o_ang   (p1_lon),
        .o_side  (p1_side)
    );

    // second pass: polar angle from vertical axis
    logic                    p2_valid;
    logic signed [W-1:0]     p2_mag;
    logic signed [ANG_W-1:0] p2_pol;
    logic [34:0]             p2_side;

    c2e_vector #(
        .W      (W),
        .SIDE_W (35),
        .STAGES (CORDIC_STAGES)
    ) u_pol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p1_valid),
        .i_x     (signed'(p1_side[W-1:0])),
        .i_y     (p1_rxy),
        .i_side  ({p1_side[W+2:W], p1_lon[31:0]}),
        .o_valid (p2_valid),
        .o_mag   (p2_mag),
        .o_ang   (p2_pol),
        .o_side  (p2_side)
    );

    // angle to pixel scaling
    logic [31:0]      pol_c;
    logic [PRODW-1:0] n_px_prod, n_py_prod, r_px_prod, r_py_prod;
    logic             r_f_valid;
    t_face            r_f_face;

    always_comb begin
        if (p2_pol < 0) begin
            pol_c = '0;
        end else if (p2_pol > HALF_TURN) begin
            pol_c = HALF_TURN[31:0];
        end else begin
            pol_c = p2_pol[31:0];
        end
        n_px_prod = PRODW'(r_pano_width) * PRODW'(p2_side[31:0]);
        n_py_prod = PRODW'(r_pano_height) * PRODW'(pol_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px_prod <= n_px_prod;
            r_py_prod <= n_py_prod;
            r_f_face  <= p2_side[34:32];
        end
    end

    logic [18:0] f_px;
    logic [17:0] f_py;
    assign f_px = r_px_prod[32-FRAC_BITS +: 19];
    assign f_py = r_py_prod[31-FRAC_BITS +: 18];

    // output register and skid register
    logic        r_ov;
    logic [18:0] r_o_px, r_s_px;
    logic [17:0] r_o_py, r_s_py;
    t_face       r_o_face, r_s_face;
    logic        take, deliver, slot_free;

    assign take      = r_ov && i_ready;
    assign deliver   = en && r_f_valid;
    assign slot_free = !r_ov || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (slot_free) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (deliver) begin
            r_ov <= 1'b1;
            if (!slot_free) begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (slot_free) begin
                r_o_px   <= r_s_px;
                r_o_py   <= r_s_py;
                r_o_face <= r_s_face;
            end
        end else if (deliver) begin
            if (slot_free) begin
                r_o_px   <= f_px;
                r_o_py   <= f_py;
                r_o_face <= r_f_face;
            end else begin
                r_s_px   <= f_px;
                r_s_py   <= f_py;
                r_s_face <= r_f_face;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_pano_x     = r_o_px;
    assign o_pano_y     = r_o_py;
    assign o_face_index = r_o_face;

    // skid is only ever filled behind a waiting output
    `C2E_ASSERT_NOW(a_skid_behind_out, r_skid_v, r_ov, "skid holds a request with output empty")
    // a drained skid refills the output register and empties
    `C2E_ASSERT_NEXT(a_skid_drain, r_skid_v && i_ready, r_ov && !r_skid_v, "skid not drained")
    // face codes beyond bottom never reach the port
    `C2E_ASSERT_NOW(a_face_range, r_ov, r_o_face <= FACE_BOTTOM, "face index out of range")

endmodule
